// ----- sv/fpie_pkg.sv -----
package fpie_pkg;

    // default width of the signed power
    localparam int FPIE_EXP_W = 32;

    // IEEE double fields
    localparam logic [10:0] FPIE_EXP_MAX = 11'h7FF;
    localparam logic [63:0] FPIE_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FPIE_ZERO    = 64'h0000_0000_0000_0000;
    localparam logic [63:0] FPIE_DEF_NAN = 64'hFFF8_0000_0000_0000;

    // operations of the shared arithmetic unit
    typedef enum logic
    {
        FPIE_OP_MUL,
        FPIE_OP_RECIP
    } fpie_op_t;

    // request into the arithmetic unit
    typedef struct packed
    {
        logic        start;
        fpie_op_t    op;
        logic [63:0] a;
        logic [63:0] b;
    } fpie_req_t;

    // response from the arithmetic unit
    typedef struct packed
    {
        logic        done;
        logic [63:0] result;
    } fpie_rsp_t;

endpackage

// ----- sv/float_power_integer_exponent.sv -----
// Raises an IEEE double base to a signed integer power by repeated squaring,
// every product rounded to nearest even. One request is taken at a time:
// req_stall stays high from acceptance until the result is loaded into the
// output register, which then holds it for the consumer while the next
// request may already start. A zero base skips the multiply loop
// (domain_error set for a power of zero or less). Otherwise the time is set
// by the shared double unit: a multiply takes longer when an operand is
// subnormal, since its leading one is brought up a bit at a time, or when the
// result is shifted into the subnormal range, a negative power adds a
// reciprocal, and the number of multiplies is popcount(|power|) +
// floor(log2(|power|)), at most 61 for a 32-bit power.
module float_power_integer_exponent
#(
    parameter int EXPONENT_WIDTH = fpie_pkg::FPIE_EXP_W
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [63:0]                      base_bits,
    input  logic signed [EXPONENT_WIDTH-1:0] exponent,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [63:0]                      result_bits,
    output logic                             domain_error
);
    import fpie_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_STEP,
        S_WAIT,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [EXPONENT_WIDTH-1:0] count_reg;
    logic [63:0]               base_reg;
    logic [63:0]               acc_reg;
    logic                      recip_reg;
    logic                      dest_acc_reg;
    logic                      derr_reg;
    logic                      rsp_valid_reg;
    logic [63:0]               result_reg;
    logic                      domain_error_reg;

    fpie_req_t                 ureq;
    fpie_rsp_t                 ursp;

    logic                      negative;
    logic [EXPONENT_WIDTH-1:0] magnitude;
    logic                      accept;

    assign negative  = exponent[EXPONENT_WIDTH-1];
    assign magnitude = negative ? (~exponent + 1'b1) : exponent;
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign req_stall = state_reg != S_IDLE;

    // issue one unit operation per loop step
    always_comb
    begin
        ureq.start = state_reg == S_STEP && (recip_reg || count_reg != '0);
        ureq.op    = recip_reg ? FPIE_OP_RECIP : FPIE_OP_MUL;
        ureq.a     = (!recip_reg && count_reg[0]) ? acc_reg : base_reg;
        ureq.b     = base_reg;
    end

    fpie_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ureq),
        .rsp   (ursp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            base_reg         <= '0;
            acc_reg          <= '0;
            recip_reg        <= 1'b0;
            dest_acc_reg     <= 1'b0;
            derr_reg         <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            result_reg       <= '0;
            domain_error_reg <= 1'b0;
        end
        else
        begin
            // output drained; S_DONE reloads it itself
            if (rsp_valid_reg && !rsp_stall && state_reg != S_DONE)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= magnitude;
                        base_reg  <= base_bits;
                        recip_reg <= negative;
                        if (base_bits[62:0] == '0)
                        begin
                            acc_reg   <= FPIE_ZERO;
                            derr_reg  <= negative || (magnitude == '0);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            acc_reg   <= FPIE_ONE;
                            derr_reg  <= 1'b0;
                            state_reg <= S_STEP;
                        end
                    end
                end

                // recip first; even count squares base, odd folds it into acc
                S_STEP:
                begin
                    if (recip_reg)
                    begin
                        dest_acc_reg <= 1'b0;
                        state_reg    <= S_WAIT;
                    end
                    else if (count_reg == '0)
                        state_reg <= S_DONE;
                    else
                    begin
                        dest_acc_reg <= count_reg[0];
                        count_reg    <= count_reg[0] ? (count_reg - 1'b1)
                                                     : (count_reg >> 1);
                        state_reg    <= S_WAIT;
                    end
                end

                S_WAIT:
                begin
                    if (ursp.done)
                    begin
                        recip_reg <= 1'b0;
                        if (dest_acc_reg)
                            acc_reg <= ursp.result;
                        else
                            base_reg <= ursp.result;
                        state_reg <= S_STEP;
                    end
                end

                S_DONE:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        result_reg       <= acc_reg;
                        domain_error_reg <= derr_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign result_bits  = result_reg;
    assign domain_error = domain_error_reg;

endmodule

// ----- sv/fpie_unit.sv -----
// Iterative double unit: a*b or 1/b, round to nearest even.
// Multiply takes four 27x27 partial products; reciprocal is restoring
// division, one quotient bit per cycle.
module fpie_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  fpie_pkg::fpie_req_t req,
    output fpie_pkg::fpie_rsp_t rsp
);
    import fpie_pkg::*;

    typedef enum logic [3:0]
    {
        U_IDLE,
        U_NORM,
        U_MUL,
        U_DIV,
        U_PACK,
        U_DENORM,
        U_ROUND,
        U_DONE
    } ustate_t;

    localparam logic signed [13:0] EMIN   = -14'sd1022;
    localparam logic signed [13:0] EFLUSH = -14'sd1079;
    localparam logic signed [13:0] BIAS   = 14'sd1023;
    localparam logic signed [13:0] BMAX   = 14'sd2047;

    ustate_t            state_reg, state_next;
    fpie_op_t           op_reg, op_next;
    logic               sr_reg, sr_next;
    logic signed [13:0] ea_reg, ea_next;
    logic signed [13:0] eb_reg, eb_next;
    logic [52:0]        ma_reg, ma_next;
    logic [52:0]        mb_reg, mb_next;
    logic [5:0]         step_reg, step_next;
    logic [105:0]       prod_reg, prod_next;
    logic [53:0]        rem_reg, rem_next;
    logic [55:0]        norm_reg, norm_next;
    logic               sticky_reg, sticky_next;
    logic signed [13:0] e_reg, e_next;
    logic [63:0]        result_reg, result_next;

    // operand decode
    logic [10:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s_xor;

    // shared multiplier
    logic [26:0]  mx, my;
    logic [53:0]  pp;
    logic [105:0] pp_sh;

    // divide step
    logic         qbit;
    logic [53:0]  rem_sub;

    // rounding
    logic         rnd_up;
    logic [53:0]  sig;
    logic signed [13:0] biased;

    always_comb
    begin
        fa     = req.a[62:52];
        fb     = req.b[62:52];
        a_nan  = (fa == FPIE_EXP_MAX) && (req.a[51:0] != '0);
        b_nan  = (fb == FPIE_EXP_MAX) && (req.b[51:0] != '0);
        a_inf  = (fa == FPIE_EXP_MAX) && (req.a[51:0] == '0);
        b_inf  = (fb == FPIE_EXP_MAX) && (req.b[51:0] == '0);
        a_zero = req.a[62:0] == '0;
        b_zero = req.b[62:0] == '0;
        s_xor  = req.a[63] ^ req.b[63];
    end

    // partial product select: low and high halves of each significand
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:
            begin
                mx    = ma_reg[26:0];
                my    = mb_reg[26:0];
            end
            2'd1:
            begin
                mx    = ma_reg[26:0];
                my    = {1'b0, mb_reg[52:27]};
            end
            2'd2:
            begin
                mx    = {1'b0, ma_reg[52:27]};
                my    = mb_reg[26:0];
            end
            default:
            begin
                mx    = {1'b0, ma_reg[52:27]};
                my    = {1'b0, mb_reg[52:27]};
            end
        endcase
        pp = mx * my;
        // high x high is at most 52 bits wide
        unique case (step_reg[1:0])
            2'd0:    pp_sh = {52'd0, pp};
            2'd1:    pp_sh = {25'd0, pp, 27'd0};
            2'd2:    pp_sh = {25'd0, pp, 27'd0};
            default: pp_sh = {pp[51:0], 54'd0};
        endcase
    end

    always_comb
    begin
        qbit    = rem_reg >= {1'b0, mb_reg};
        rem_sub = qbit ? (rem_reg - {1'b0, mb_reg}) : rem_reg;
    end

    always_comb
    begin
        rnd_up = norm_reg[2] & (norm_reg[3] | norm_reg[1] | norm_reg[0] | sticky_reg);
        sig    = {1'b0, norm_reg[55:3]} + {53'd0, rnd_up};
        biased = e_reg + BIAS + {13'd0, sig[53]};
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        sr_next     = sr_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        step_next   = step_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        norm_next   = norm_reg;
        sticky_next = sticky_reg;
        e_next      = e_reg;
        result_next = result_reg;

        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    state_next = U_NORM;
                    ea_next    = (fa == '0) ? EMIN : ($signed({3'b000, fa}) - BIAS);
                    eb_next    = (fb == '0) ? EMIN : ($signed({3'b000, fb}) - BIAS);
                    ma_next    = {fa != '0, req.a[51:0]};
                    mb_next    = {fb != '0, req.b[51:0]};
                    if (req.op == FPIE_OP_MUL)
                    begin
                        sr_next = s_xor;
                        priority if (a_nan)
                        begin
                            result_next = req.a | (64'd1 << 51);
                            state_next  = U_DONE;
                        end
                        else if (b_nan)
                        begin
                            result_next = req.b | (64'd1 << 51);
                            state_next  = U_DONE;
                        end
                        else if ((a_inf && b_zero) || (a_zero && b_inf))
                        begin
                            result_next = FPIE_DEF_NAN;
                            state_next  = U_DONE;
                        end
                        else if (a_inf || b_inf)
                        begin
                            result_next = {s_xor, FPIE_EXP_MAX, 52'd0};
                            state_next  = U_DONE;
                        end
                        else if (a_zero || b_zero)
                        begin
                            result_next = {s_xor, 63'd0};
                            state_next  = U_DONE;
                        end
                    end
                    else
                    begin
                        sr_next = req.b[63];
                        ma_next = {1'b1, 52'd0};
                        priority if (b_nan)
                        begin
                            result_next = req.b | (64'd1 << 51);
                            state_next  = U_DONE;
                        end
                        else if (b_inf)
                        begin
                            result_next = {req.b[63], 63'd0};
                            state_next  = U_DONE;
                        end
                        else if (b_zero)
                        begin
                            result_next = {req.b[63], FPIE_EXP_MAX, 52'd0};
                            state_next  = U_DONE;
                        end
                    end
                end
            end

            // subnormal operands: bring leading one up, one bit a cycle
            U_NORM:
            begin
                step_next = '0;
                prod_next = '0;
                rem_next  = {2'b00, 1'b1, 51'd0} << 1;
                rem_next  = 54'd1 << 52;
                priority if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - 14'sd1;
                end
                else if (!mb_reg[52])
                begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - 14'sd1;
                end
                else
                    state_next = (op_reg == FPIE_OP_MUL) ? U_MUL : U_DIV;
            end

            U_MUL:
            begin
                prod_next = prod_reg + pp_sh;
                step_next = step_reg + 6'd1;
                if (step_reg[1:0] == 2'd3)
                    state_next = U_PACK;
            end

            U_DIV:
            begin
                rem_next  = {rem_sub[52:0], 1'b0};
                prod_next = {prod_reg[104:0], qbit};
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd56)
                    state_next = U_PACK;
            end

            // align to a 56-bit word with the leading one on top
            U_PACK:
            begin
                state_next = U_DENORM;
                if (op_reg == FPIE_OP_MUL)
                begin
                    if (prod_reg[105])
                    begin
                        norm_next   = prod_reg[105:50];
                        sticky_next = |prod_reg[49:0];
                        e_next      = ea_reg + eb_reg + 14'sd1;
                    end
                    else
                    begin
                        norm_next   = prod_reg[104:49];
                        sticky_next = |prod_reg[48:0];
                        e_next      = ea_reg + eb_reg;
                    end
                end
                else
                begin
                    if (prod_reg[56])
                    begin
                        norm_next   = prod_reg[56:1];
                        sticky_next = prod_reg[0] | (rem_reg != '0);
                        e_next      = -eb_reg;
                    end
                    else
                    begin
                        norm_next   = prod_reg[55:0];
                        sticky_next = rem_reg != '0;
                        e_next      = -eb_reg - 14'sd1;
                    end
                end
            end

            // tiny results: shift right into subnormal range, or flush when far below it
            U_DENORM:
            begin
                priority if (e_reg < EFLUSH)
                begin
                    norm_next   = '0;
                    sticky_next = 1'b1;
                    e_next      = EMIN;
                end
                else if (e_reg < EMIN)
                begin
                    norm_next   = {1'b0, norm_reg[55:1]};
                    sticky_next = sticky_reg | norm_reg[0];
                    e_next      = e_reg + 14'sd1;
                end
                else
                    state_next = U_ROUND;
            end

            U_ROUND:
            begin
                state_next = U_DONE;
                if (norm_reg[55])
                begin
                    if (biased >= BMAX)
                        result_next = {sr_reg, FPIE_EXP_MAX, 52'd0};
                    else
                        result_next = {sr_reg, biased[10:0], sig[53] ? 52'd0 : sig[51:0]};
                end
                else
                    result_next = {sr_reg, 10'd0, sig[52], sig[51:0]};
            end

            U_DONE:
                state_next = U_IDLE;

            default:
                state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            op_reg     <= FPIE_OP_MUL;
            sr_reg     <= 1'b0;
            ea_reg     <= '0;
            eb_reg     <= '0;
            ma_reg     <= '0;
            mb_reg     <= '0;
            step_reg   <= '0;
            prod_reg   <= '0;
            rem_reg    <= '0;
            norm_reg   <= '0;
            sticky_reg <= 1'b0;
            e_reg      <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            sr_reg     <= sr_next;
            ea_reg     <= ea_next;
            eb_reg     <= eb_next;
            ma_reg     <= ma_next;
            mb_reg     <= mb_next;
            step_reg   <= step_next;
            prod_reg   <= prod_next;
            rem_reg    <= rem_next;
            norm_reg   <= norm_next;
            sticky_reg <= sticky_next;
            e_reg      <= e_next;
            result_reg <= result_next;
        end
    end

    assign rsp.done   = state_reg == U_DONE;
    assign rsp.result = result_reg;

endmodule
